// ===== hw/rtl/tccw_pkg.sv =====
// Shared constants, codes and types for the text console character writer.
`timescale 1ns / 1ps
package tccw_pkg;
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam logic [15:0] BLANK_CELL = 16'h0F20;
    localparam logic [7:0]  ATTR_BYTE  = 8'h0F;
    localparam logic [7:0]  CH_BS  = 8'h08;
    localparam logic [7:0]  CH_TAB = 8'h09;
    localparam logic [7:0]  CH_LF  = 8'h0A;
    localparam logic [7:0]  CH_CR  = 8'h0D;
    localparam logic [2:0] OP_PUT    = 3'd0;
    localparam logic [2:0] OP_SETCUR = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_INSERT = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture op fields
        logic cursor_upd; // apply cursor math for op
        logic scroll_fix; // after scroll: row to last, hw update
        logic addr_init;  // start a sweep
        logic addr_step;  // advance sweep
        logic mem_rd;     // issue read at sweep source
        logic mem_wr;     // write sweep destination
        logic wr_char;    // write printable char at cursor
        logic rd_cell;    // issue read of read_index
        logic out_fire;   // present result
    } tccw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_scroll;
        logic sweep_last;
        logic printable;
    } tccw_sts_t;
endpackage

// ===== hw/rtl/text_console_char_writer_top.sv =====
// Top level of the text console character writer.
// Channel   Signals                                              Direction
// command   start, busy, op, char_code, new_column, new_row, read_index   in (busy out)
// result    done, cell_data, cursor_column, cursor_row, hw_cursor_location out
// config    cfg_valid, cfg_ready, cfg_data                       in (cfg_ready out)
// Set cursor and unused ops pass through the execute and output states; put char and read cell add a read wait state.
// Clear, delete line, insert line and a scrolling put char walk the cell
// store one cell a cycle through its single write port.
// After reset a clearing pass over all ROWS*COLUMNS cells holds busy high.
// The result strobe done lasts one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module text_console_char_writer_top #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [7:0]  char_code,
    input  logic [6:0]  new_column,
    input  logic [4:0]  new_row,
    input  logic [10:0] read_index,
    output logic        done,
    output logic [15:0] cell_data,
    output logic [6:0]  cursor_column,
    output logic [4:0]  cursor_row,
    output logic [10:0] hw_cursor_location,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import tccw_pkg::*;
    tccw_cmd_t cmd;
    tccw_sts_t sts;
    logic      slm_reg;
    logic      clearing_reg;
    logic [$clog2(COLUMNS*ROWS+1)-1:0] clr_cnt_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slm_reg <= 1'b0;
            clearing_reg <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                slm_reg <= cfg_data;
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ($bits(clr_cnt_reg))'(COLUMNS*ROWS - 1))
                    clearing_reg <= 1'b0;
            end
        end
    end

    tccw_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .clearing(clearing_reg),
        .op(op), .busy(busy), .done(done), .cmd(cmd), .sts(sts)
    );

    tccw_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .single_line_mode(slm_reg), .op(op), .char_code(char_code),
        .new_column(new_column), .new_row(new_row), .read_index(read_index),
        .cell_data(cell_data), .cursor_column(cursor_column),
        .cursor_row(cursor_row), .hw_cursor_location(hw_cursor_location)
    );
endmodule

// ===== hw/rtl/tccw_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/tccw_datapath.sv =====
// Datapath: cursor registers, sweep address counters and cell store.
`timescale 1ns / 1ps
module tccw_datapath #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tccw_pkg::tccw_cmd_t cmd,
    output tccw_pkg::tccw_sts_t sts,
    input  logic                single_line_mode,
    input  logic [2:0]          op,
    input  logic [7:0]          char_code,
    input  logic [6:0]          new_column,
    input  logic [4:0]          new_row,
    input  logic [10:0]         read_index,
    output logic [15:0]         cell_data,
    output logic [6:0]          cursor_column,
    output logic [4:0]          cursor_row,
    output logic [10:0]         hw_cursor_location
);
    import tccw_pkg::*;
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS + 1);

    logic [2:0]  op_reg;
    logic [7:0]  ch_reg;
    logic [6:0]  ncol_reg;
    logic [4:0]  nrow_reg;
    logic [10:0] ridx_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [10:0] hw_reg, hw_next;
    logic [AW:0] src_reg, dst_reg, end_reg;
    logic        blank_reg;   // sweep writes blanks only
    logic        down_reg;    // sweep runs downward
    logic [AW:0] src_init, dst_init, end_init;
    logic        blank_init, down_init;
    logic        clr_reg;     // reset clearing pass
    logic        rd_pend_reg;
    logic        rd_ok_reg;
    logic [15:0] out_data_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata, rdata;

    tccw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    function automatic logic [10:0] lin(input logic [RW-1:0] r, input logic [CW-1:0] c);
        logic [31:0] v;
        v = 32'(r) * 32'(COLUMNS) + 32'(c);
        return v[10:0];
    endfunction

    logic printable;
    assign printable = (ch_reg >= 8'h20) && !ch_reg[7];

    // cursor update for put char / set cursor / clear
    always_comb
    begin
        logic [CW:0] c;
        logic [RW:0] r;
        c = {1'b0, col_reg};
        r = {1'b0, row_reg};
        col_next = col_reg;
        row_next = row_reg;
        hw_next  = hw_reg;
        case (op_reg)
            OP_PUT:
            begin
                if (ch_reg == CH_BS)
                begin
                    if (c != '0)
                        c = c - 1'b1;
                    else if (r != '0)
                    begin
                        r = r - 1'b1;
                        c = (CW+1)'(COLUMNS - 1);
                    end
                end
                else if (ch_reg == CH_TAB)
                    c = (c + (CW+1)'(8)) & ~(CW+1)'(7);
                else if (ch_reg == CH_CR)
                    c = '0;
                else if (ch_reg == CH_LF)
                begin
                    c = '0;
                    r = r + 1'b1;
                end
                else if (printable)
                    c = c + 1'b1;
                if (c >= (CW+1)'(COLUMNS))
                begin
                    c = '0;
                    r = r + 1'b1;
                end
                if (r > (RW+1)'(ROWS))
                    r = (RW+1)'(ROWS);
                col_next = c[CW-1:0];
                row_next = r[RW-1:0];
                if (!single_line_mode)
                    hw_next = lin(row_next, col_next);
            end
            OP_SETCUR:
            begin
                col_next = (32'(ncol_reg) < COLUMNS) ? CW'(ncol_reg) : CW'(COLUMNS - 1);
                row_next = (32'(nrow_reg) < ROWS) ? RW'(nrow_reg) : RW'(ROWS - 1);
                hw_next  = lin(row_next, col_next);
            end
            OP_CLEAR:
            begin
                col_next = '0;
                row_next = '0;
                hw_next  = '0;
            end
            default: ;
        endcase
    end

    // sweep setup per op
    always_comb
    begin
        logic [10:0] rb;
        rb = lin(row_reg, '0);
        src_init = '0; dst_init = '0; end_init = (AW+1)'(CELLS);
        blank_init = 1'b1; down_init = 1'b0;
        case (op_reg)
            OP_PUT:
            begin
                src_init = (AW+1)'(COLUMNS); blank_init = 1'b0;
            end
            OP_CLEAR: ;
            OP_DELETE:
            begin
                if (32'(row_reg) < ROWS - 1)
                begin
                    dst_init = (AW+1)'(rb); src_init = (AW+1)'(rb) + (AW+1)'(COLUMNS);
                    blank_init = 1'b0;
                end
                else
                    dst_init = (AW+1)'(CELLS - COLUMNS);
            end
            OP_INSERT:
            begin
                blank_init = 1'b0;
                if (32'(row_reg) >= ROWS)
                    // off-screen row: one-cell self copy, store unchanged
                    end_init = (AW+1)'(1);
                else
                begin
                    // move downward from the end, then blank cursor row
                    down_init = 1'b1;
                    dst_init = (AW+1)'(CELLS - 1);
                    src_init = (AW+1)'(CELLS - 1 - COLUMNS);
                    end_init = (AW+1)'(rb);
                end
            end
            default: ;
        endcase
    end

    // sweep: the source address runs one cell ahead to cover the registered read
    logic [AW:0] blank_from;
    always_comb
    begin
        logic wr_sweep;
        wr_sweep = cmd.mem_wr || clr_reg;
        we    = 1'b0;
        waddr = dst_reg[AW-1:0];
        wdata = BLANK_CELL;
        raddr = src_reg[AW-1:0];
        if (clr_reg)
        begin
            we = 1'b1;
        end
        else if (cmd.wr_char)
        begin
            we    = 32'(row_reg) < ROWS;
            waddr = AW'(lin(row_reg, col_reg));
            wdata = {ATTR_BYTE, ch_reg};
        end
        else if (wr_sweep)
        begin
            we = 1'b1;
            if (!blank_reg && (down_reg ? (dst_reg >= blank_from) : (dst_reg < blank_from)))
                wdata = rdata;
        end
        if (cmd.rd_cell)
            raddr = AW'(ridx_reg);
    end
    // non-blank region boundary
    always_comb
    begin
        blank_from = down_reg ? end_reg + (AW+1)'(COLUMNS) : (AW+1)'(CELLS - COLUMNS);
    end

    assign sts.need_scroll = (32'(row_reg) >= ROWS) && !single_line_mode;
    assign sts.sweep_last  = down_reg ? (dst_reg == end_reg) : (dst_reg == end_reg - 1'b1);
    assign sts.printable   = printable && (op_reg == OP_PUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0; row_reg <= '0; hw_reg <= '0;
            clr_reg <= 1'b1; dst_reg <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd_cell;
            if (clr_reg)
            begin
                dst_reg <= dst_reg + 1'b1;
                if (dst_reg == (AW+1)'(CELLS - 1))
                    clr_reg <= 1'b0;
            end
            else if (cmd.addr_init)
            begin
                src_reg <= src_init; dst_reg <= dst_init; end_reg <= end_init;
                blank_reg <= blank_init; down_reg <= down_init;
            end
            else if (cmd.addr_step)
            begin
                if (down_reg)
                begin
                    src_reg <= src_reg - 1'b1; dst_reg <= dst_reg - 1'b1;
                end
                else
                begin
                    src_reg <= src_reg + 1'b1; dst_reg <= dst_reg + 1'b1;
                end
            end
            else if (cmd.mem_rd)
            begin
                // first read issued: source moves one ahead
                if (down_reg)
                    src_reg <= src_reg - 1'b1;
                else
                    src_reg <= src_reg + 1'b1;
            end
            if (cmd.cursor_upd)
            begin
                col_reg <= col_next; row_reg <= row_next; hw_reg <= hw_next;
            end
            if (cmd.scroll_fix)
            begin
                row_reg <= RW'(ROWS - 1);
                hw_reg  <= lin(RW'(ROWS - 1), col_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op; ch_reg <= char_code; ncol_reg <= new_column;
            nrow_reg <= new_row; ridx_reg <= read_index;
            out_data_reg <= '0;
            rd_ok_reg <= (op == OP_READ) && (32'(read_index) < CELLS);
        end
        if (rd_pend_reg && rd_ok_reg)
            out_data_reg <= rdata;
    end

    assign cell_data          = out_data_reg;
    assign cursor_column      = 7'(col_reg);
    assign cursor_row         = 5'(row_reg);
    assign hw_cursor_location = hw_reg;
endmodule

// ===== hw/rtl/tccw_ctrl.sv =====
// Controller state machine sequencing each command.
`timescale 1ns / 1ps
module tccw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                clearing,
    input  logic [2:0]          op,
    output logic                busy,
    output logic                done,
    output tccw_pkg::tccw_cmd_t cmd,
    input  tccw_pkg::tccw_sts_t sts
);
    import tccw_pkg::*;
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_PRIME = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_RWAIT = 3'd4;
    localparam logic [2:0] S_RDONE = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg;
    logic       scroll_reg, scroll_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        scroll_next = scroll_reg;
        done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !clearing)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                scroll_next = 1'b0;
                case (op_reg)
                    OP_PUT:
                    begin
                        cmd.wr_char = sts.printable;
                        cmd.cursor_upd = 1'b1;
                        state_next = S_RWAIT;
                    end
                    OP_CLEAR, OP_DELETE, OP_INSERT:
                    begin
                        cmd.cursor_upd = 1'b1;
                        cmd.addr_init = 1'b1;
                        state_next = S_PRIME;
                    end
                    OP_READ:
                    begin
                        cmd.rd_cell = 1'b1;
                        state_next = S_RWAIT;
                    end
                    default:
                    begin
                        cmd.cursor_upd = 1'b1;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_RWAIT:
            begin
                if (op_reg == OP_PUT && sts.need_scroll)
                begin
                    cmd.addr_init = 1'b1;
                    scroll_next = 1'b1;
                    state_next = S_PRIME;
                end
                else
                    state_next = S_OUT;
            end
            S_PRIME:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.mem_wr = 1'b1;
                cmd.addr_step = 1'b1;
                if (sts.sweep_last)
                    state_next = S_RDONE;
            end
            S_RDONE:
            begin
                cmd.scroll_fix = scroll_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.out_fire = 1'b1;
                done = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE) || clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            scroll_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scroll_reg <= scroll_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            op_reg <= op;
    end
endmodule

// ===== hw/rtl/tccw_checker.sv =====
// Port-level checker for the text console character writer, with bind.
`timescale 1ns / 1ps
module tccw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [6:0]  cursor_column,
    input logic [4:0]  cursor_row
);
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accept did not raise busy");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result beat outside command");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result beat repeated");
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cursor_column < 7'd80) else $error("column out of range");
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cursor_row <= 5'd25) else $error("row out of range");
endmodule

bind text_console_char_writer_top tccw_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .cursor_column(cursor_column), .cursor_row(cursor_row)
);

// ===== tb/sv/tb_text_console_char_writer_top.sv =====
// Self-checking testbench for the text console character writer top level.
`timescale 1ns / 1ps
module tb_text_console_char_writer_top;
    import tccw_pkg::*;

    localparam int NCOL  = COLUMNS_DEF;
    localparam int NROW  = ROWS_DEF;
    localparam int NCELL = NCOL * NROW;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int SETTLE = NCELL + 20;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  char_code;
        logic [6:0]  new_column;
        logic [4:0]  new_row;
        logic [10:0] read_index;
    } cmd_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [10:0] hw_cursor_location;
    } status_t;

    logic        clk, rst_n;
    logic        start, busy, done;
    logic [2:0]  op;
    logic [7:0]  char_code;
    logic [6:0]  new_column;
    logic [4:0]  new_row;
    logic [10:0] read_index;
    logic [15:0] cell_data;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] hw_cursor_location;
    logic        cfg_valid, cfg_ready, cfg_data;

    text_console_char_writer_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .char_code(char_code), .new_column(new_column), .new_row(new_row),
        .read_index(read_index), .done(done), .cell_data(cell_data),
        .cursor_column(cursor_column), .cursor_row(cursor_row),
        .hw_cursor_location(hw_cursor_location), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    cmd_t    pending_cmds[$];
    status_t expected_status[$];
    cmd_t    cur_cmd;
    int      send_idle_pct;
    int      errors;

    // console shadow
    logic [15:0] screen[NCELL];
    int          col_q, row_q, hw_q;
    bit          single_line;

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    function automatic void blank_line(int r);
        if (r < NROW)
            for (int i = 0; i < NCOL; i++) screen[r * NCOL + i] = BLANK_CELL;
    endfunction

    function automatic void console_apply(cmd_t c);
        status_t s;
        int      ch;
        s = '0;
        ch = c.char_code;
        case (c.op)
            OP_PUT:
            begin
                if (ch == CH_BS)
                begin
                    if (col_q != 0) col_q--;
                    else if (row_q != 0)
                    begin
                        row_q--;
                        col_q = NCOL - 1;
                    end
                end
                else if (ch == CH_TAB) col_q = (col_q + 8) & ~7;
                else if (ch == CH_CR) col_q = 0;
                else if (ch == CH_LF)
                begin
                    col_q = 0;
                    row_q++;
                end
                else if (ch >= 8'h20 && ch < 8'h80)
                begin
                    if (row_q < NROW && col_q < NCOL)
                        screen[row_q * NCOL + col_q] = {ATTR_BYTE, c.char_code};
                    col_q++;
                end
                if (col_q >= NCOL)
                begin
                    col_q = 0;
                    row_q++;
                end
                if (row_q > NROW) row_q = NROW;
                if (!single_line)
                begin
                    if (row_q >= NROW)
                    begin
                        for (int i = 0; i < NCELL - NCOL; i++) screen[i] = screen[i + NCOL];
                        blank_line(NROW - 1);
                        row_q = NROW - 1;
                    end
                    hw_q = (row_q * NCOL + col_q) & 11'h7FF;
                end
            end
            OP_SETCUR:
            begin
                col_q = (c.new_column < NCOL) ? c.new_column : NCOL - 1;
                row_q = (c.new_row < NROW) ? c.new_row : NROW - 1;
                hw_q = (row_q * NCOL + col_q) & 11'h7FF;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NCELL; i++) screen[i] = BLANK_CELL;
                col_q = 0;
                row_q = 0;
                hw_q = 0;
            end
            OP_DELETE:
            begin
                if (row_q < NROW - 1)
                    for (int i = row_q * NCOL; i < NCELL - NCOL; i++)
                        screen[i] = screen[i + NCOL];
                blank_line(NROW - 1);
            end
            OP_INSERT:
            begin
                if (row_q < NROW)
                begin
                    for (int i = NCELL - 1; i >= (row_q + 1) * NCOL; i--)
                        screen[i] = screen[i - NCOL];
                    blank_line(row_q);
                end
            end
            OP_READ:
                if (c.read_index < NCELL) s.cell_data = screen[c.read_index];
            default: ;
        endcase
        s.cursor_column = col_q[6:0];
        s.cursor_row = row_q[4:0];
        s.hw_cursor_location = hw_q[10:0];
        expected_status.push_back(s);
    endfunction

    function automatic cmd_t mk(logic [2:0] o, logic [7:0] ch = 0, logic [6:0] cl = 0,
                                logic [4:0] rw = 0, logic [10:0] ix = 0);
        cmd_t c;
        c.op = o; c.char_code = ch; c.new_column = cl; c.new_row = rw; c.read_index = ix;
        return c;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   p, q;
        c = cmd_t'($bits(cmd_t)'({$urandom, $urandom}));
        p = $urandom_range(99);
        if (p < 60)
        begin
            c.op = OP_PUT;
            q = $urandom_range(99);
            if (q < 12) c.char_code = CH_LF;
            else if (q < 18) c.char_code = CH_BS;
            else if (q < 23) c.char_code = CH_TAB;
            else if (q < 26) c.char_code = CH_CR;
            else if (q < 34) c.char_code = 8'($urandom_range(255, 128));
            else if (q < 37) c.char_code = 8'($urandom_range(31));
            else c.char_code = 8'($urandom_range(127, 32));
        end
        else if (p < 75) c.op = OP_SETCUR;
        else if (p < 77) c.op = OP_CLEAR;
        else if (p < 82) c.op = OP_DELETE;
        else if (p < 87) c.op = OP_INSERT;
        else if (p < 98) c.op = OP_READ;
        else c.op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
        return c;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            op <= '0; char_code <= '0; new_column <= '0; new_row <= '0; read_index <= '0;
        end
        else
        begin
            if (start && !busy) console_apply(cur_cmd);
            if (!(start && busy))
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    op <= cur_cmd.op;
                    char_code <= cur_cmd.char_code;
                    new_column <= cur_cmd.new_column;
                    new_row <= cur_cmd.new_row;
                    read_index <= cur_cmd.read_index;
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        status_t got, want;
        if (rst_n && done)
        begin
            got = {cell_data, cursor_column, cursor_row, hw_cursor_location};
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected data=%h col=%0d row=%0d hw=%0d", $time,
                             want.cell_data, want.cursor_column, want.cursor_row,
                             want.hw_cursor_location);
                    $display("%0t:          actual   data=%h col=%0d row=%0d hw=%0d", $time,
                             got.cell_data, got.cursor_column, got.cursor_row,
                             got.hw_cursor_location);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        wait (pending_cmds.size() == 0 && !start && expected_status.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(bit v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        forever
        begin
            @(posedge clk);
            if (cfg_valid && cfg_ready) break;
        end
        single_line = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(int n);
        repeat (n) pending_cmds.push_back(rand_cmd());
    endtask

    initial
    begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        for (int i = 0; i < NCELL; i++) screen[i] = BLANK_CELL;
        col_q = 0; row_q = 0; hw_q = 0; single_line = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_mode(1'b0);
        pending_cmds.push_back(mk(OP_PUT, 8'h41));
        pending_cmds.push_back(mk(OP_PUT, 8'h7F));
        pending_cmds.push_back(mk(OP_PUT, 8'h20));
        pending_cmds.push_back(mk(OP_PUT, 8'h80));
        pending_cmds.push_back(mk(OP_PUT, 8'hFF));
        pending_cmds.push_back(mk(OP_PUT, 8'h00));
        pending_cmds.push_back(mk(OP_PUT, CH_TAB));
        pending_cmds.push_back(mk(OP_PUT, CH_CR));
        pending_cmds.push_back(mk(OP_PUT, CH_LF));
        pending_cmds.push_back(mk(OP_PUT, CH_BS));
        pending_cmds.push_back(mk(OP_SETCUR, 0, 0, 0));
        pending_cmds.push_back(mk(OP_PUT, CH_BS));
        pending_cmds.push_back(mk(OP_SETCUR, 0, 7'h7F, 5'h1F));
        pending_cmds.push_back(mk(OP_PUT, 8'h5A));
        pending_cmds.push_back(mk(OP_PUT, CH_BS));
        pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 11'd0));
        pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 11'd1919));
        pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 11'd1999));
        pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 11'h7FF));
        pending_cmds.push_back(mk(OP_DELETE));
        pending_cmds.push_back(mk(OP_SETCUR, 0, 7'd5, 5'd3));
        pending_cmds.push_back(mk(OP_INSERT));
        pending_cmds.push_back(mk(OP_DELETE));
        pending_cmds.push_back(mk(OP_SPARE6));
        pending_cmds.push_back(mk(OP_SPARE7));
        pending_cmds.push_back(mk(OP_CLEAR));
        drain();

        send_idle_pct = 31;
        queue_random(130);
        drain();

        // single-line: run onto the off-screen row
        write_mode(1'b1);
        send_idle_pct = 86;
        pending_cmds.push_back(mk(OP_SETCUR, 0, 7'd79, 5'd24));
        pending_cmds.push_back(mk(OP_PUT, 8'h41));
        pending_cmds.push_back(mk(OP_PUT, 8'h42));
        pending_cmds.push_back(mk(OP_PUT, CH_LF));
        pending_cmds.push_back(mk(OP_INSERT));
        pending_cmds.push_back(mk(OP_DELETE));
        pending_cmds.push_back(mk(OP_PUT, CH_BS));
        queue_random(120);
        drain();

        write_mode(1'b0);
        send_idle_pct = 0;
        pending_cmds.push_back(mk(OP_PUT, 8'h43));
        queue_random(140);
        drain();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
